[rtl/core/rgb_window_convolution_defines.svh]
// Assertion macros shared by the checker files of the window convolution block.
// Depends on nothing; included by name where assertions are written.
`ifndef RGB_WINDOW_CONVOLUTION_DEFINES_SVH
`define RGB_WINDOW_CONVOLUTION_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define RWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window convolution check failed");

// Next-cycle implication, switched off while reset is asserted.
`define RWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window convolution check failed");

`endif

[rtl/core/rwc_pkg.sv]
// Shared types and constants of the RGB window convolution block.
// No dependencies; imported by the top level, rwc_cell and rwc_checker.
`default_nettype none

package rwc_pkg;

    localparam int PIX_W      = 8;
    localparam int WEIGHT_W   = 12;
    localparam int WIDX_W     = 4;
    localparam int WREG_W     = 11;
    localparam int HEIGHT_W   = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int CFG_DATA_W = 13;
    // Room for up to 49 taps of 9-bit pixels times 12-bit weights.
    localparam int ACC_W      = 28;

    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_DRAIN  = 2'd1,
        OP_WEIGHT = 2'd2
    } t_op;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Partial window sums travelling down the cell chain.
    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic signed [ACC_W-1:0] acc_red;
        logic signed [ACC_W-1:0] acc_green;
        logic signed [ACC_W-1:0] acc_blue;
    } t_wave;

endpackage

`default_nettype wire

[rtl/core/rwc_pix_if.sv]
// Input stream interface: pixels, drain requests and weight loads.
// Depends on nothing.
`default_nettype none

interface rwc_pix_if;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [7:0]        pixel_red;
    logic [7:0]        pixel_green;
    logic [7:0]        pixel_blue;
    logic [3:0]        weight_index;
    logic signed [11:0] weight_value;

    modport source (output valid, op, pixel_red, pixel_green, pixel_blue,
                    weight_index, weight_value, input ready);
    modport sink (input valid, op, pixel_red, pixel_green, pixel_blue,
                  weight_index, weight_value, output ready);
endinterface

`default_nettype wire

[rtl/core/rwc_res_if.sv]
// Result stream interface: filtered pixels with frame and saturation flags.
// Depends on nothing.
`default_nettype none

interface rwc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
    logic       clipped;

    modport source (output valid, out_red, out_green, out_blue, frame_end, clipped,
                    input ready);
    modport sink (input valid, out_red, out_green, out_blue, frame_end, clipped,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/rgb_window_convolution.sv]
// Top level of the RGB window convolution: counters, tap sequencer, cell chain, output.
// Depends on rwc_pkg, rwc_pix_if, rwc_res_if, rwc_line_mem and rwc_cell.
//
//   port       dir   transfer carries
//   i_pix      in    op, pixel_red/green/blue, weight_index, weight_value
//   o_res      out   out_red/green/blue, frame_end, clipped
//   i_cfg_*    in    register writes: image_width (0), image_height (1)
//
// An item that gives no result is taken without a stall. An item that gives a result holds
// i_pix.ready low until its result is registered; its window walk starts once o_res is free:
// the single read port of the line memory delivers one window pixel per cycle.
// Reset is synchronous; the line memory is not cleared and is read only where written.
// A stalled o_res holds its result; the next item is still taken meanwhile.
`default_nettype none

module rgb_window_convolution #(
    parameter int KERNEL_SIZE = 3,
    parameter int MAX_WIDTH   = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [rwc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rwc_pix_if.sink                           i_pix,
    rwc_res_if.source                         o_res
);
    import rwc_pkg::*;

    localparam int HALF = KERNEL_SIZE / 2;
    localparam int KK   = KERNEL_SIZE * KERNEL_SIZE;
    localparam int RING = KERNEL_SIZE * MAX_WIDTH;
    localparam int AW   = $clog2(RING);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int KCW  = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
    localparam int UW   = CW + 2;
    localparam int VW   = HEIGHT_W + 2;

    // Configuration and effective frame size.
    logic [WREG_W-1:0]   r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    logic [WW-1:0]       ew;
    logic [HEIGHT_W-1:0] eh;
    logic [PW-1:0]       dly;

    // Input side.
    logic [CW-1:0]       r_in_col;
    logic [HEIGHT_W-1:0] r_in_row;
    logic [AW-1:0]       r_in_addr;
    logic [PW-1:0]       r_pend;
    logic                in_done;

    // Output position.
    logic [CW-1:0]       r_out_col;
    logic [HEIGHT_W-1:0] r_out_row;
    logic [AW-1:0]       r_top_base;

    // Sequencer.
    logic                r_busy;
    logic                r_armed;
    logic                r_issuing;
    logic                r_last;
    logic [KCW-1:0]      r_kx;
    logic [KCW-1:0]      r_ky;
    logic signed [UW-1:0] r_u;
    logic signed [VW-1:0] r_v;
    logic [AW-1:0]       r_rowaddr;
    logic                r_inj_valid;
    logic                r_inj_last;

    logic [CW-1:0]       col;
    logic [AW:0]         asum;
    logic [AW-1:0]       raddr;
    logic [AW:0]         rstep;
    logic [AW:0]         tstep;
    logic signed [VW-1:0] vn;
    logic [23:0]         rdata;

    logic                accept;
    logic                pix_take;
    logic                is_last_tap;
    logic [PW-1:0]       pend_inc;

    // Output register.
    logic                r_o_valid;
    logic [7:0]          r_o_red;
    logic [7:0]          r_o_green;
    logic [7:0]          r_o_blue;
    logic                r_o_frame_end;
    logic                r_o_clipped;

    t_wave               waves [KK+1];
    t_wave               tail;

    assign ew = (r_image_width == '0) ? WW'(1) :
                (int'(r_image_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_image_width);
    assign eh = (r_image_height == '0) ? HEIGHT_W'(1) :
                (int'(r_image_height) > MAX_HEIGHT) ? HEIGHT_W'(MAX_HEIGHT) : r_image_height;
    assign dly = PW'(HALF) * PW'(ew) + PW'(HALF);

    assign in_done  = (r_in_row >= eh);
    assign accept   = i_pix.valid && i_pix.ready;
    assign pix_take = accept && (t_op'(i_pix.op) == OP_PIXEL) && !in_done;
    assign pend_inc = r_pend + PW'(1);
    assign i_pix.ready = !r_busy;

    // Clamped column and ring address of the current tap, plus the next row and top-base steps.
    always_comb begin
        if (r_u[UW-1]) begin
            col = '0;
        end else if (int'(r_u) >= int'(ew)) begin
            col = CW'(ew - WW'(1));
        end else begin
            col = CW'(r_u);
        end
        asum  = {1'b0, r_rowaddr} + (AW+1)'(col);
        raddr = (int'(asum) >= RING) ? AW'(int'(asum) - RING) : AW'(asum);
        rstep = {1'b0, r_rowaddr} + (AW+1)'(ew);
        tstep = {1'b0, r_top_base} + (AW+1)'(ew);
        vn    = r_v + VW'(1);
    end

    assign is_last_tap = (r_kx == KCW'(KERNEL_SIZE - 1)) && (r_ky == KCW'(KERNEL_SIZE - 1));

    rwc_line_mem #(.DEPTH(RING), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (pix_take),
        .i_waddr (r_in_addr),
        .i_wdata ({i_pix.pixel_blue, i_pix.pixel_green, i_pix.pixel_red}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        waves[0]           = '0;
        waves[0].valid     = r_inj_valid;
        waves[0].last      = r_inj_last;
    end

    for (genvar t = 0; t < KK; t++) begin : g_cell
        rwc_cell #(.KERNEL_SIZE(KERNEL_SIZE), .TAP(t)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_px    (rdata),
            .i_wave  (waves[t]),
            .i_wload (accept && (t_op'(i_pix.op) == OP_WEIGHT)),
            .i_widx  (i_pix.weight_index),
            .i_wval  (i_pix.weight_value),
            .o_wave  (waves[t+1])
        );
    end

    assign tail = waves[KK];

    function automatic logic [8:0] sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        sh = acc >>> 8;
        if (acc < 0) begin
            sat = {1'b1, 8'd0};
        end else if (sh > 255) begin
            sat = {1'b1, 8'd255};
        end else begin
            sat = {1'b0, sh[7:0]};
        end
    endfunction

    logic [8:0] s_red;
    logic [8:0] s_green;
    logic [8:0] s_blue;
    assign s_red   = sat(tail.acc_red);
    assign s_green = sat(tail.acc_green);
    assign s_blue  = sat(tail.acc_blue);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WREG_W'(1024);
            r_image_height <= HEIGHT_W'(1024);
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_in_addr      <= '0;
            r_pend         <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_top_base     <= '0;
            r_busy         <= 1'b0;
            r_armed        <= 1'b0;
            r_issuing      <= 1'b0;
            r_inj_valid    <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            r_inj_valid <= r_issuing && (r_kx == '0) && (r_ky == '0);
            r_inj_last  <= r_last;

            if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end

            if (accept) begin
                case (t_op'(i_pix.op))
                    OP_PIXEL: begin
                        if (!in_done) begin
                            if (WW'(r_in_col) == ew - WW'(1)) begin
                                r_in_col <= '0;
                                r_in_row <= r_in_row + HEIGHT_W'(1);
                            end else begin
                                r_in_col <= r_in_col + CW'(1);
                            end
                            r_in_addr <= (int'(r_in_addr) == RING - 1) ? '0 :
                                         r_in_addr + AW'(1);
                            r_pend <= pend_inc;
                            if (pend_inc > dly) begin
                                r_busy  <= 1'b1;
                                r_armed <= 1'b1;
                            end
                        end
                    end
                    OP_DRAIN: begin
                        if (in_done) begin
                            r_busy  <= 1'b1;
                            r_armed <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Start the window walk once the output register is free.
            if (r_armed && !r_o_valid) begin
                r_armed   <= 1'b0;
                r_issuing <= 1'b1;
                r_kx      <= '0;
                r_ky      <= '0;
                r_u       <= $signed(UW'(r_out_col)) - UW'(HALF);
                r_v       <= $signed(VW'(r_out_row)) - VW'(HALF);
                r_rowaddr <= r_top_base;
                r_last    <= (r_out_row == eh - HEIGHT_W'(1)) &&
                             (WW'(r_out_col) == ew - WW'(1));
            end

            if (r_issuing) begin
                if (r_kx == KCW'(KERNEL_SIZE - 1)) begin
                    r_kx <= '0;
                    r_ky <= r_ky + KCW'(1);
                    r_u  <= $signed(UW'(r_out_col)) - UW'(HALF);
                    r_v  <= vn;
                    if ((int'(vn) >= 1) && (int'(vn) <= int'(eh) - 1)) begin
                        r_rowaddr <= (int'(rstep) >= RING) ? AW'(int'(rstep) - RING) :
                                     AW'(rstep);
                    end
                end else begin
                    r_kx <= r_kx + KCW'(1);
                    r_u  <= r_u + UW'(1);
                end

                if (is_last_tap) begin
                    r_issuing <= 1'b0;
                    if (r_last) begin
                        r_in_col   <= '0;
                        r_in_row   <= '0;
                        r_in_addr  <= '0;
                        r_pend     <= '0;
                        r_out_col  <= '0;
                        r_out_row  <= '0;
                        r_top_base <= '0;
                    end else begin
                        r_pend <= r_pend - PW'(1);
                        if (WW'(r_out_col) == ew - WW'(1)) begin
                            r_out_col <= '0;
                            r_out_row <= r_out_row + HEIGHT_W'(1);
                            if (int'(r_out_row) + 1 > HALF) begin
                                r_top_base <= (int'(tstep) >= RING) ?
                                              AW'(int'(tstep) - RING) : AW'(tstep);
                            end
                        end else begin
                            r_out_col <= r_out_col + CW'(1);
                        end
                    end
                end
            end

            if (tail.valid) begin
                r_o_valid <= 1'b1;
                r_busy    <= 1'b0;
            end

            if (i_cfg_we) begin
                if (i_cfg_index == REG_IMAGE_WIDTH) begin
                    r_image_width <= i_cfg_data[WREG_W-1:0];
                end else begin
                    r_image_height <= i_cfg_data[HEIGHT_W-1:0];
                end
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_addr  <= '0;
                r_pend     <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_top_base <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail.valid) begin
            r_o_red       <= s_red[7:0];
            r_o_green     <= s_green[7:0];
            r_o_blue      <= s_blue[7:0];
            r_o_clipped   <= s_red[8] | s_green[8] | s_blue[8];
            r_o_frame_end <= tail.last;
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.out_red   = r_o_red;
    assign o_res.out_green = r_o_green;
    assign o_res.out_blue  = r_o_blue;
    assign o_res.frame_end = r_o_frame_end;
    assign o_res.clipped   = r_o_clipped;
endmodule

`default_nettype wire

[rtl/core/rwc_line_mem.sv]
// Ring line memory holding the last rows of the frame, one write and one read port.
// Depends on nothing; read data is registered.
`default_nettype none

module rwc_line_mem #(
    parameter int DEPTH = 3072,
    parameter int AW    = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [23:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [23:0]   o_rdata
);
    logic [23:0] r_mem [DEPTH];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

[rtl/core/rwc_cell.sv]
// One tap of the window: holds its weight and adds its product to the passing wave.
// Depends on rwc_pkg.
`default_nettype none

module rwc_cell #(
    parameter int KERNEL_SIZE = 3,
    parameter int TAP         = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [23:0]          i_px,
    input  wire rwc_pkg::t_wave       i_wave,
    input  wire logic                 i_wload,
    input  wire logic [3:0]           i_widx,
    input  wire logic signed [11:0]   i_wval,
    output rwc_pkg::t_wave            o_wave
);
    import rwc_pkg::*;

    // Taps are visited row by row; the weight table is ordered column first.
    localparam int WIDX = (TAP % KERNEL_SIZE) * KERNEL_SIZE + TAP / KERNEL_SIZE;

    logic signed [WEIGHT_W-1:0] r_weight;
    t_wave                      r_wave;
    t_wave                      n_wave;
    logic signed [20:0]         p_red;
    logic signed [20:0]         p_green;
    logic signed [20:0]         p_blue;

    assign p_red   = $signed({1'b0, i_px[7:0]})   * r_weight;
    assign p_green = $signed({1'b0, i_px[15:8]})  * r_weight;
    assign p_blue  = $signed({1'b0, i_px[23:16]}) * r_weight;

    always_comb begin
        n_wave           = i_wave;
        n_wave.acc_red   = i_wave.acc_red   + ACC_W'(p_red);
        n_wave.acc_green = i_wave.acc_green + ACC_W'(p_green);
        n_wave.acc_blue  = i_wave.acc_blue  + ACC_W'(p_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if (i_wload && (int'(i_widx) == WIDX)) begin
            r_weight <= i_wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave.valid <= 1'b0;
        end else begin
            r_wave <= n_wave;
        end
    end

    assign o_wave = r_wave;
endmodule

`default_nettype wire

[rtl/core/rwc_checker.sv]
// Port-level checks of the RGB window convolution, bound to the top level.
// Depends on rwc_pkg, rgb_window_convolution_defines.svh and rgb_window_convolution.
`default_nettype none

`include "rgb_window_convolution_defines.svh"

module rwc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic [1:0] i_in_op,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_red,
    input wire logic [7:0] i_out_green,
    input wire logic [7:0] i_out_blue,
    input wire logic       i_out_frame_end,
    input wire logic       i_out_clipped
);
    import rwc_pkg::*;

    // A stalled result stays offered and unchanged.
    `RWC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `RWC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_red) && $stable(i_out_green) && $stable(i_out_blue) && $stable(i_out_frame_end) && $stable(i_out_clipped))
    // A weight load never starts a window walk.
    `RWC_ASSERT_NEXT(a_weight_free, i_clk, i_rst_n, i_in_valid && i_in_ready && (t_op'(i_in_op) == OP_WEIGHT), i_in_ready)
    // Saturation always lands on a range limit.
    `RWC_ASSERT_NOW(a_clip_limit, i_clk, i_rst_n, i_out_valid && i_out_clipped, (i_out_red == 8'd0) || (i_out_red == 8'd255) || (i_out_green == 8'd0) || (i_out_green == 8'd255) || (i_out_blue == 8'd0) || (i_out_blue == 8'd255))
endmodule

bind rgb_window_convolution rwc_checker u_rwc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pix.valid),
    .i_in_ready      (i_pix.ready),
    .i_in_op         (i_pix.op),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_red       (o_res.out_red),
    .i_out_green     (o_res.out_green),
    .i_out_blue      (o_res.out_blue),
    .i_out_frame_end (o_res.frame_end),
    .i_out_clipped   (o_res.clipped)
);

`default_nettype wire
